@@ rtl/pidaw_pkg.sv @@
// Shared types, codes and constants of the PID controller with integral clamp.
// Holds the microcode control word and the read-only microprogram.
// No dependencies.
`default_nettype none

package pidaw_pkg;

  localparam int unsigned UPC_W   = 3;
  localparam int unsigned REG_W   = 32;
  localparam int unsigned CIDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CIDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_STEP_TIME  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_STEP_INV   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_INT_UPPER  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_INT_LOWER  = 3'd6;

  // Register reset values.
  localparam logic signed [31:0] RST_GAIN      = 32'sd0;
  localparam logic [30:0]        RST_STEP_TIME = 31'd65536;
  localparam logic [30:0]        RST_STEP_INV  = 31'd65536;
  localparam logic signed [31:0] RST_INT_UPPER = 32'sd131072;
  localparam logic signed [31:0] RST_INT_LOWER = -32'sd131072;

  // Sequencer advance conditions.
  localparam logic [1:0] COND_ALWAYS = 2'd0;
  localparam logic [1:0] COND_IN     = 2'd1;
  localparam logic [1:0] COND_OUT    = 2'd2;

  // Multiplier operand pairs.
  localparam logic [2:0] MUL_NONE     = 3'd0;
  localparam logic [2:0] MUL_ERR_DT   = 3'd1;
  localparam logic [2:0] MUL_ERR_INV  = 3'd2;
  localparam logic [2:0] MUL_LAST_INV = 3'd3;
  localparam logic [2:0] MUL_P_ERR    = 3'd4;
  localparam logic [2:0] MUL_I_INT    = 3'd5;
  localparam logic [2:0] MUL_D_RATE   = 3'd6;

  // Accumulator operations.
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // Microprogram step addresses.
  localparam logic [UPC_W-1:0] S_IDLE     = 3'd0;
  localparam logic [UPC_W-1:0] S_MUL_DT   = 3'd1;
  localparam logic [UPC_W-1:0] S_INTEG    = 3'd2;
  localparam logic [UPC_W-1:0] S_LAST     = 3'd3;
  localparam logic [UPC_W-1:0] S_RATE     = 3'd4;
  localparam logic [UPC_W-1:0] S_TERM_I   = 3'd5;
  localparam logic [UPC_W-1:0] S_TERM_D   = 3'd6;
  localparam logic [UPC_W-1:0] S_OUT      = 3'd7;

  typedef struct packed {
    logic [1:0]       cond;
    logic [UPC_W-1:0] next;
    logic [2:0]       mul_op;
    logic [1:0]       acc_op;
    logic             ld_err;
    logic             upd_int;
    logic             upd_last;
    logic             ld_rate;
    logic             ld_out;
  } uword_t;

  typedef struct packed {
    logic       fire;
    logic [2:0] mul_op;
    logic [1:0] acc_op;
    logic       ld_err;
    logic       upd_int;
    logic       upd_last;
    logic       ld_rate;
    logic       ld_out;
  } ctrl_t;

  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{cond: COND_ALWAYS, next: S_IDLE, mul_op: MUL_NONE, acc_op: ACC_HOLD,
          ld_err: 1'b0, upd_int: 1'b0, upd_last: 1'b0, ld_rate: 1'b0, ld_out: 1'b0};
    case (addr)
      S_IDLE: begin
        w.cond   = COND_IN;
        w.next   = S_MUL_DT;
        w.ld_err = 1'b1;
      end
      S_MUL_DT: begin
        w.next   = S_INTEG;
        w.mul_op = MUL_ERR_DT;
      end
      S_INTEG: begin
        w.next    = S_LAST;
        w.mul_op  = MUL_ERR_INV;
        w.upd_int = 1'b1;
      end
      S_LAST: begin
        w.next     = S_RATE;
        w.mul_op   = MUL_LAST_INV;
        w.acc_op   = ACC_LOAD;
        w.upd_last = 1'b1;
      end
      S_RATE: begin
        w.next    = S_TERM_I;
        w.mul_op  = MUL_P_ERR;
        w.acc_op  = ACC_SUB;
        w.ld_rate = 1'b1;
      end
      S_TERM_I: begin
        w.next   = S_TERM_D;
        w.mul_op = MUL_I_INT;
        w.acc_op = ACC_LOAD;
      end
      S_TERM_D: begin
        w.next   = S_OUT;
        w.mul_op = MUL_D_RATE;
        w.acc_op = ACC_ADD;
      end
      S_OUT: begin
        w.cond   = COND_OUT;
        w.next   = S_IDLE;
        w.acc_op = ACC_ADD;
        w.ld_out = 1'b1;
      end
      default: begin
        w.next = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pid_controller_antiwindup.sv @@
// Each transfer on the input channel takes a setpoint and a measured value and
// yields one result transfer with the saturated Q16.16 drive and an integral
// clamp flag. A sample runs through every step of the microprogram, which runs
// every product through one shared 32x32 multiplier. The next input is taken
// as soon as the program returns to its first step, even while the previous
// result waits; the last step waits only when an earlier result is still held
// under stall. Registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while idle, as the block does not enforce it.
// Depends on pidaw_pkg, pidaw_seq and pidaw_dp.
`default_nettype none

module pid_controller_antiwindup (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [pidaw_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [pidaw_pkg::REG_W-1:0]  cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [31:0]           in_target,
  input  wire logic signed [31:0]           in_measurement,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [31:0]                out_drive,
  output logic                              out_integral_limited
);
  import pidaw_pkg::*;

  ctrl_t ctrl;
  logic  out_busy;

  pidaw_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  pidaw_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctrl                 (ctrl),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_target            (in_target),
    .in_measurement       (in_measurement),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_drive            (out_drive),
    .out_integral_limited (out_integral_limited),
    .out_busy             (out_busy)
  );

endmodule

`default_nettype wire

@@ rtl/pidaw_seq.sv @@
// Microcode sequencer: step counter, program table lookup and conditional advance.
// Depends on pidaw_pkg.
`default_nettype none

module pidaw_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            out_busy,
  output logic                 in_stall,
  output pidaw_pkg::ctrl_t     ctrl
);
  import pidaw_pkg::*;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  uword_t           word;
  logic             adv;

  assign word = ucode(upc_r);

  always_comb begin
    case (word.cond)
      COND_ALWAYS: adv = 1'b1;
      COND_IN:     adv = in_valid;
      COND_OUT:    adv = !out_busy;
      default:     adv = 1'b0;
    endcase
    upc_nxt = adv ? word.next : upc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign in_stall = (upc_r != S_IDLE);

  assign ctrl = '{fire: adv, mul_op: word.mul_op, acc_op: word.acc_op,
                  ld_err: word.ld_err, upd_int: word.upd_int, upd_last: word.upd_last,
                  ld_rate: word.ld_rate, ld_out: word.ld_out};

endmodule

`default_nettype wire

@@ rtl/pidaw_dp.sv @@
// Datapath: configuration registers, shared 32x32 multiplier, accumulator,
// controller state and the output register. Depends on pidaw_pkg.
`default_nettype none

module pidaw_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pidaw_pkg::ctrl_t           ctrl,
  input  wire logic                       cfg_we,
  input  wire logic [pidaw_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [pidaw_pkg::REG_W-1:0]  cfg_data,
  input  wire logic signed [31:0]         in_target,
  input  wire logic signed [31:0]         in_measurement,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output logic signed [31:0]              out_drive,
  output logic                            out_integral_limited,
  output logic                            out_busy
);
  import pidaw_pkg::*;

  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic [30:0]        step_time_r, step_inv_r;
  logic signed [31:0] int_upper_r, int_lower_r;

  logic signed [31:0] err_r, integ_r, last_r, rate_r;
  logic               limited_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r;

  logic               out_valid_r;
  logic signed [31:0] out_drive_r;
  logic               out_lim_r;

  logic signed [32:0] diff;
  logic signed [31:0] err_sat;
  logic signed [31:0] mul_a, mul_b;
  logic signed [47:0] int_inc, int_next;
  logic signed [31:0] int_clamped;
  logic               int_hit;
  logic signed [65:0] prod_x, acc_sum;
  logic               out_take;

  function automatic logic signed [31:0] sat_q16(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v >>> 16;
    if (s > 66'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -66'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  always_comb begin
    diff = 33'(in_target) - 33'(in_measurement);
    if (diff[32] != diff[31]) begin
      err_sat = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_sat = diff[31:0];
    end
  end

  always_comb begin
    case (ctrl.mul_op)
      MUL_ERR_DT: begin
        mul_a = err_r;
        mul_b = $signed({1'b0, step_time_r});
      end
      MUL_ERR_INV: begin
        mul_a = err_r;
        mul_b = $signed({1'b0, step_inv_r});
      end
      MUL_LAST_INV: begin
        mul_a = last_r;
        mul_b = $signed({1'b0, step_inv_r});
      end
      MUL_P_ERR: begin
        mul_a = gain_p_r;
        mul_b = err_r;
      end
      MUL_I_INT: begin
        mul_a = gain_i_r;
        mul_b = integ_r;
      end
      MUL_D_RATE: begin
        mul_a = gain_d_r;
        mul_b = rate_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The increment is the Q32.32 product of error and period, floored to Q16.16.
  always_comb begin
    int_inc  = 48'(prod_r >>> 16);
    int_next = 48'(integ_r) + int_inc;
    int_hit  = 1'b1;
    if (int_next > 48'(int_upper_r)) begin
      int_clamped = int_upper_r;
    end else if (int_next < 48'(int_lower_r)) begin
      int_clamped = int_lower_r;
    end else begin
      int_clamped = int_next[31:0];
      int_hit     = 1'b0;
    end
  end

  always_comb begin
    prod_x = 66'(prod_r);
    case (ctrl.acc_op)
      ACC_LOAD: acc_sum = prod_x;
      ACC_ADD:  acc_sum = acc_r + prod_x;
      ACC_SUB:  acc_sum = acc_r - prod_x;
      default:  acc_sum = acc_r;
    endcase
  end

  assign out_take = out_valid_r && !out_stall;
  assign out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= RST_GAIN;
      gain_i_r    <= RST_GAIN;
      gain_d_r    <= RST_GAIN;
      step_time_r <= RST_STEP_TIME;
      step_inv_r  <= RST_STEP_INV;
      int_upper_r <= RST_INT_UPPER;
      int_lower_r <= RST_INT_LOWER;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:    gain_p_r    <= $signed(cfg_data);
        REG_GAIN_I:    gain_i_r    <= $signed(cfg_data);
        REG_GAIN_D:    gain_d_r    <= $signed(cfg_data);
        REG_STEP_TIME: step_time_r <= cfg_data[30:0];
        REG_STEP_INV:  step_inv_r  <= cfg_data[30:0];
        REG_INT_UPPER: int_upper_r <= $signed(cfg_data);
        REG_INT_LOWER: int_lower_r <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.fire && ctrl.upd_int) begin
        integ_r <= int_clamped;
      end
      if (ctrl.fire && ctrl.upd_last) begin
        last_r <= err_r;
      end
      if (ctrl.fire && ctrl.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      if (ctrl.ld_err) begin
        err_r <= err_sat;
      end
      if (ctrl.mul_op != MUL_NONE) begin
        prod_r <= mul_a * mul_b;
      end
      if (ctrl.acc_op != ACC_HOLD) begin
        acc_r <= acc_sum;
      end
      if (ctrl.upd_int) begin
        limited_r <= int_hit;
      end
      if (ctrl.ld_rate) begin
        rate_r <= sat_q16(acc_sum);
      end
      if (ctrl.ld_out) begin
        out_drive_r <= sat_q16(acc_sum);
        out_lim_r   <= limited_r;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drive            = out_drive_r;
  assign out_integral_limited = out_lim_r;

endmodule

`default_nettype wire

@@ rtl/pidaw_checker.sv @@
// Port-level checker for pid_controller_antiwindup and its bind statement.
// Depends on the top level's ports only.
`default_nettype none

module pidaw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_drive,
  input wire logic        out_integral_limited
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_busy_window: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall ##1 in_stall
    ##1 in_stall ##1 in_stall)
    else $error("input accepted while a sample is still in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive)
    && $stable(out_integral_limited))
    else $error("stalled result changed");

  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_xfer, 8))
    else $error("result appeared without an input transfer eight cycles earlier");

endmodule

bind pid_controller_antiwindup pidaw_checker u_pidaw_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_drive            (out_drive),
  .out_integral_limited (out_integral_limited)
);

`default_nettype wire
